[rtl/cts_pkg.sv]
`timescale 1ns / 1ps

package cts_pkg;

	localparam int POS_W       = 10;
	localparam int LEN_W       = 11;
	localparam int RAD_W       = 6;
	localparam int DATA_W      = 32;
	localparam int WGT_W       = RAD_W + 1;
	localparam int PROD_W      = DATA_W + WGT_W + 1;
	localparam int ACC_W       = 45;
	localparam int QUO_W       = 32;
	localparam int REM_W       = ACC_W - QUO_W;
	localparam int DIV_W       = 2 * WGT_W - 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic REG_RING_LENGTH = 1'b0;
	localparam logic REG_RADIUS      = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_QUERY,
		OP_ERROR
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [POS_W-1:0]          pos;
		logic signed [DATA_W-1:0]  value;
	} entry_t;

	typedef struct packed {
		logic                      err;
		logic [POS_W-1:0]          pos;
		logic signed [ACC_W-1:0]   sum;
	} job_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [RAD_W-1:0] radius;
	} cfg_t;

endpackage

[rtl/cts_front.sv]
`timescale 1ns / 1ps

module cts_front (
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            kind,
	input  logic [cts_pkg::POS_W-1:0]       position,
	input  logic signed [cts_pkg::DATA_W-1:0] sample_value,
	input  cts_pkg::cfg_t                   cfg,
	input  logic                            queue_full,
	output logic                            push,
	output cts_pkg::entry_t                 entry
);
	import cts_pkg::*;

	logic in_range;

	assign in_range   = {1'b0, position} < cfg.length;
	assign item_ready = !queue_full;

	// drop stores outside the ring; queries always go on, flagged if out of range
	assign push = item_valid && item_ready && (kind == KIND_QUERY || in_range);

	always_comb begin
		entry.pos   = position;
		entry.value = sample_value;
		if (kind == KIND_STORE) begin
			entry.op = OP_STORE;
		end else if (in_range) begin
			entry.op = OP_QUERY;
		end else begin
			entry.op = OP_ERROR;
		end
	end

endmodule

[rtl/cts_queue.sv]
`timescale 1ns / 1ps

module cts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cts_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output cts_pkg::entry_t head
);
	import cts_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

endmodule

[rtl/cts_accum.sv]
`timescale 1ns / 1ps

module cts_accum #(
	parameter int MAX_POINTS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cts_pkg::cfg_t   cfg,
	input  logic            head_valid,
	input  cts_pkg::entry_t head,
	output logic            pop,
	output logic            job_valid,
	input  logic            job_ready,
	output cts_pkg::job_t   job
);
	import cts_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FWD   = 2'd1;
	localparam logic [1:0] ST_BWD   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]                state_q;
	logic [LEN_W-1:0]          idx_q;
	logic [LEN_W-1:0]          center_q;
	logic [WGT_W-1:0]          wgt_q;
	logic [POS_W-1:0]          pos_q;
	logic                      err_q;

	logic signed [DATA_W-1:0]  mem [MAX_POINTS];
	logic signed [DATA_W-1:0]  rdata_s1;
	logic [WGT_W-1:0]          wgt_s1;
	logic                      vld_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      vld_s2;
	logic signed [ACC_W-1:0]   acc_q;

	logic                      issue;
	logic                      wr_en;
	logic [LEN_W-1:0]          last_idx;
	logic [LEN_W-1:0]          idx_up;
	logic [LEN_W-1:0]          idx_dn;
	logic [LEN_W-1:0]          center_dn;

	assign last_idx  = cfg.length - LEN_W'(1);
	assign idx_up    = (idx_q == last_idx) ? '0 : idx_q + LEN_W'(1);
	assign idx_dn    = (idx_q == '0) ? last_idx : idx_q - LEN_W'(1);
	assign center_dn = (center_q == '0) ? last_idx : center_q - LEN_W'(1);

	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign wr_en     = pop && head.op == OP_STORE;
	assign issue     = (state_q == ST_FWD) || (state_q == ST_BWD);
	assign job_valid = (state_q == ST_DRAIN) && !vld_s1 && !vld_s2;

	assign job.err = err_q;
	assign job.pos = pos_q;
	assign job.sum = acc_q;

	// sample store: one write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(head.pos)] <= head.value;
		end
		rdata_s1 <= mem[AW'(idx_q)];
	end

	always_ff @(posedge clk) begin
		wgt_s1  <= wgt_q;
		prod_s2 <= rdata_s1 * $signed({1'b0, wgt_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.op == OP_QUERY) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q    <= LEN_W'(head.pos);
			center_q <= LEN_W'(head.pos);
			wgt_q    <= WGT_W'(cfg.radius) + WGT_W'(1);
			pos_q    <= head.pos;
			err_q    <= head.op == OP_ERROR;
		end else if (state_q == ST_FWD && wgt_q == WGT_W'(1)) begin
			idx_q <= center_dn;
			wgt_q <= WGT_W'(cfg.radius);
		end else if (issue) begin
			idx_q <= (state_q == ST_FWD) ? idx_up : idx_dn;
			wgt_q <= wgt_q - WGT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.op)
							OP_QUERY: state_q <= ST_FWD;
							OP_ERROR: state_q <= ST_DRAIN;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FWD: begin
					if (wgt_q == WGT_W'(1)) begin
						state_q <= (cfg.radius == '0) ? ST_DRAIN : ST_BWD;
					end
				end
				ST_BWD: begin
					if (wgt_q == WGT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (job_valid && job_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && $past(state_q) != ST_DRAIN) |-> ##2 !vld_s2)
		else $error("product pipeline not empty two cycles into drain");

endmodule

[rtl/cts_divider.sv]
`timescale 1ns / 1ps

module cts_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [cts_pkg::RAD_W-1:0]         radius,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  cts_pkg::job_t                     job,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [cts_pkg::POS_W-1:0]         result_position,
	output logic signed [cts_pkg::DATA_W-1:0] smoothed_value,
	output logic                              status
);
	import cts_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]          state_q;
	logic [ACC_W-1:0]    mag_q;
	logic [DIV_W-1:0]    dvs_q;
	logic [REM_W-1:0]    rem_q;
	logic [QUO_W-1:0]    low_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic                err_q;
	logic [POS_W-1:0]    pos_q;
	logic                res_valid_q;

	logic                accept;
	logic                out_free;
	logic [WGT_W-1:0]    wgt;
	logic [ACC_W-1:0]    num;
	logic [REM_W:0]      trial;
	logic                qbit;

	assign job_ready    = state_q == ST_IDLE;
	assign accept       = job_valid && job_ready;
	assign out_free     = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;

	assign wgt   = WGT_W'(radius) + WGT_W'(1);
	assign num   = mag_q + ACC_W'(dvs_q >> 1);
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign qbit  = trial >= (REM_W+1)'(dvs_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mag_q <= job.sum[ACC_W-1] ? ACC_W'(-job.sum) : ACC_W'(job.sum);
					neg_q <= job.sum[ACC_W-1];
					err_q <= job.err;
					pos_q <= job.pos;
					dvs_q <= DIV_W'(wgt) * DIV_W'(wgt);
				end
			end
			ST_ADD: begin
				// rounding bias, then the top bits seed the remainder (always below divisor)
				rem_q <= num[ACC_W-1:QUO_W];
				low_q <= num[QUO_W-1:0];
				cnt_q <= '0;
			end
			ST_ITER: begin
				rem_q <= qbit ? REM_W'(trial - (REM_W+1)'(dvs_q)) : REM_W'(trial);
				low_q <= {low_q[QUO_W-2:0], qbit};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= job.err ? ST_FIN : ST_ADD;
					end
				end
				ST_ADD:  state_q <= ST_ITER;
				ST_ITER: begin
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			result_position <= pos_q;
			status          <= err_q ? STATUS_RANGE : STATUS_OK;
			if (err_q) begin
				smoothed_value <= '0;
			end else begin
				smoothed_value <= neg_q ? $signed(-low_q) : $signed(low_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ITER |-> {1'b0, rem_q} < (REM_W+1)'(dvs_q))
		else $error("partial remainder not below divisor");

endmodule

[rtl/circular_triangular_smoother.sv]
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// item      item_valid / item_ready     kind, position, sample_value
// result    result_valid / result_ready result_position, smoothed_value, status
// config    APB psel/penable/pwrite     paddr, pwdata -> prdata (pready tied high)
//
// A store writes the sample ring as it leaves the queue. A query walks its window,
// one sample read per cycle, through the accumulator (memory read port, multiplier,
// drain). A 32-step restoring divider then rounds the sum while the accumulator
// walks the next query's window.
// Reset clears control state only; the sample ring holds no reset value.
// The item side stalls only when the four-entry queue is full; the result
// register parts the divider from a stalled consumer.

module circular_triangular_smoother #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_RADIUS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cts_pkg::PADDR_W-1:0]       paddr,
	input  logic [cts_pkg::PDATA_W-1:0]       pwdata,
	output logic [cts_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,

	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic                              kind,
	input  logic [cts_pkg::POS_W-1:0]         position,
	input  logic signed [cts_pkg::DATA_W-1:0] sample_value,

	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [cts_pkg::POS_W-1:0]         result_position,
	output logic signed [cts_pkg::DATA_W-1:0] smoothed_value,
	output logic                              status
);
	import cts_pkg::*;

	// Hold the caps inside what the register fields can express.
	localparam int LEN_CAP = (MAX_POINTS < 2**LEN_W - 1) ? MAX_POINTS : 2**LEN_W - 1;
	localparam int RAD_CAP = (MAX_RADIUS < 2**RAD_W - 1) ? MAX_RADIUS : 2**RAD_W - 1;

	logic [LEN_W-1:0] ring_length_q;
	logic [RAD_W-1:0] radius_q;
	cfg_t             cfg;
	logic             cfg_write;

	logic             push;
	entry_t           push_entry;
	logic             queue_full;
	logic             pop;
	logic             head_valid;
	entry_t           head;

	logic             job_valid;
	logic             job_ready;
	job_t             job;

	// Register file: a write lands on the access phase of the transfer.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_length_q <= LEN_W'(1024);
			radius_q      <= '0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_RING_LENGTH: ring_length_q <= pwdata[LEN_W-1:0];
				REG_RADIUS:      radius_q      <= pwdata[RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RING_LENGTH: prdata = PDATA_W'(ring_length_q);
			REG_RADIUS:      prdata = PDATA_W'(radius_q);
			default:         prdata = '0;
		endcase
	end

	// Effective settings: length zero acts as one, both saturate at their caps.
	always_comb begin
		if (ring_length_q == '0) begin
			cfg.length = LEN_W'(1);
		end else if (ring_length_q > LEN_W'(LEN_CAP)) begin
			cfg.length = LEN_W'(LEN_CAP);
		end else begin
			cfg.length = ring_length_q;
		end
		cfg.radius = (radius_q > RAD_W'(RAD_CAP)) ? RAD_W'(RAD_CAP) : radius_q;
	end

	// Front end: classify each transfer and drop out-of-range stores.
	cts_front u_front (
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.position     (position),
		.sample_value (sample_value),
		.cfg          (cfg),
		.queue_full   (queue_full),
		.push         (push),
		.entry        (push_entry)
	);

	// Keep stores and queries in order between the two halves.
	cts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end, part one: sample ring and weighted window sum.
	cts_accum #(
		.MAX_POINTS (MAX_POINTS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	// Back end, part two: round to nearest by the weight total and hold the result.
	cts_divider u_divider (
		.clk             (clk),
		.arst_n          (arst_n),
		.radius          (cfg.radius),
		.job_valid       (job_valid),
		.job_ready       (job_ready),
		.job             (job),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result_position (result_position),
		.smoothed_value  (smoothed_value),
		.status          (status)
	);

endmodule
